>>> rtl/tcr_pkg.sv
package tcr_pkg;

  localparam int LIT_COUNT   = 28;
  localparam int LIT_MAX_LEN = 8;
  localparam int POS_W       = $clog2(LIT_MAX_LEN);

  typedef logic [7:0]           byte_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [LIT_COUNT-1:0] lit_vec_t;

  // bits 0-5 keywords, 6-19 operators, 20-27 specials
  localparam lit_vec_t KW_MASK = lit_vec_t'(28'h000003F);
  localparam lit_vec_t OP_MASK = lit_vec_t'(28'h00FFFC0);
  localparam lit_vec_t SP_MASK = lit_vec_t'(28'hFF00000);

  localparam byte_t NUL   = 8'h00;
  localparam byte_t QUOTE = 8'h27;

  localparam byte_t LIT_TEXT [LIT_COUNT][LIT_MAX_LEN] = '{
    '{"i", "n", "t", NUL, NUL, NUL, NUL, NUL},
    '{"c", "h", "a", "r", NUL, NUL, NUL, NUL},
    '{"r", "e", "t", "u", "r", "n", NUL, NUL},
    '{"i", "f", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"e", "l", "s", "e", NUL, NUL, NUL, NUL},
    '{"w", "h", "i", "l", "e", NUL, NUL, NUL},
    '{"=", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"!", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"+", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"-", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"*", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"/", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"=", "=", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"!", "=", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"<", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{">", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"<", "=", NUL, NUL, NUL, NUL, NUL, NUL},
    '{">", "=", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"&", "&", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"|", "|", NUL, NUL, NUL, NUL, NUL, NUL},
    '{"[", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"]", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"(", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{")", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"{", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"}", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{";", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{",", NUL, NUL, NUL, NUL, NUL, NUL, NUL}
  };

  localparam pos_t LIT_LEN [LIT_COUNT] = '{
    3'd3, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
  };

  localparam pos_t POS_MAX = '1;

  typedef enum logic [2:0] {
    TC_KEYWORD  = 3'd0,
    TC_OPERATOR = 3'd1,
    TC_SPECIAL  = 3'd2,
    TC_IDENT    = 3'd3,
    TC_NUMBER   = 3'd4,
    TC_CHAR_LIT = 3'd5,
    TC_ERROR    = 3'd6
  } tclass_t;

  typedef struct packed {
    lit_vec_t literal_match;
    pos_t     char_position;
    logic     ident_ok;
    logic     digits_ok;
    logic     opens_with_quote;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    literal_match:    '1,
    char_position:    '0,
    ident_ok:         1'b1,
    digits_ok:        1'b1,
    opens_with_quote: 1'b0
  };

  typedef struct packed {
    logic full_kw;
    logic full_op;
    logic full_sp;
    logic id_now;
    logic num_now;
    logic quote_close;
  } scan_flags_t;

endpackage

>>> rtl/tcr_scan.sv
module tcr_scan (
  input  tcr_pkg::scan_state_t cur,
  input  tcr_pkg::byte_t       ch,
  input  logic                 last,
  output tcr_pkg::scan_state_t nxt,
  output tcr_pkg::scan_flags_t flags
);
  import tcr_pkg::*;

  lit_vec_t hit;
  lit_vec_t full;
  logic     is_alpha;
  logic     is_digit;
  logic     quote_first;
  pos_t     pos;

  assign pos = cur.char_position;

  // one compare per fixed literal, all in parallel
  always_comb begin
    for (int i = 0; i < LIT_COUNT; i++) begin
      hit[i]  = cur.literal_match[i] && (pos < LIT_LEN[i]) && (LIT_TEXT[i][pos] == ch);
      full[i] = hit[i] && (({1'b0, pos} + 4'd1) == {1'b0, LIT_LEN[i]});
    end
  end

  assign is_alpha    = ch inside {[8'd65:8'd90], [8'd97:8'd122], 8'd95};
  assign is_digit    = ch inside {[8'd48:8'd57]};
  assign quote_first = (pos == '0) ? (ch == QUOTE) : cur.opens_with_quote;

  assign flags.full_kw     = |(full & KW_MASK);
  assign flags.full_op     = |(full & OP_MASK);
  assign flags.full_sp     = |(full & SP_MASK);
  assign flags.id_now      = cur.ident_ok && (is_alpha || ((pos != '0) && is_digit));
  assign flags.num_now     = cur.digits_ok && is_digit;
  assign flags.quote_close = quote_first && (ch == QUOTE);

  // end of token puts the scanner back to its reset state
  always_comb begin
    if (last) begin
      nxt = SCAN_RESET;
    end else begin
      nxt.literal_match    = hit;
      nxt.char_position    = (pos == POS_MAX) ? POS_MAX : pos + pos_t'(1);
      nxt.ident_ok         = flags.id_now;
      nxt.digits_ok        = flags.num_now;
      nxt.opens_with_quote = quote_first;
    end
  end

endmodule

>>> rtl/tcr_classify.sv
module tcr_classify (
  input  tcr_pkg::scan_flags_t flags,
  output tcr_pkg::tclass_t     cls
);
  import tcr_pkg::*;

  // priority pick over the class tests
  always_comb begin
    if (flags.full_kw) begin
      cls = TC_KEYWORD;
    end else if (flags.full_op) begin
      cls = TC_OPERATOR;
    end else if (flags.full_sp) begin
      cls = TC_SPECIAL;
    end else if (flags.id_now) begin
      cls = TC_IDENT;
    end else if (flags.num_now) begin
      cls = TC_NUMBER;
    end else if (flags.quote_close) begin
      cls = TC_CHAR_LIT;
    end else begin
      cls = TC_ERROR;
    end
  end

endmodule

>>> rtl/token_class_recognizer_top.sv
// a token's final character passes the input register and then the result register, which
//   drives its class onto the result port
// throughput: one character per cycle, set by the single scan pass between the two registers;
//   a final character waits only while an earlier class sits on a stalled result port
// reset: synchronous rst empties both registers and returns the scan state to the start of
//   a token
module token_class_recognizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] token_class
);
  import tcr_pkg::*;

  // input register: one request waiting for the scan pass
  logic  s1_valid;
  byte_t s1_ch;
  logic  s1_last;

  // per-token scan state, advanced once per scanned character
  scan_state_t state;
  scan_state_t state_next;
  scan_flags_t flags;
  tclass_t     cls;

  // result register
  tclass_t res_class;

  logic res_free;
  logic s1_adv;

  // result register can load when empty or being drained this cycle
  assign res_free = !res_valid || !res_stall;

  // a character that ends no token never needs the result register
  assign s1_adv = s1_valid && (!s1_last || res_free);

  // hold a new request only while the scanned one cannot move on
  assign req_stall = s1_valid && !s1_adv;

  tcr_scan u_scan (
    .cur   (state),
    .ch    (s1_ch),
    .last  (s1_last),
    .nxt   (state_next),
    .flags (flags)
  );

  tcr_classify u_classify (
    .flags (flags),
    .cls   (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      state     <= SCAN_RESET;
    end else begin
      if (!req_stall) begin
        s1_valid <= req_valid;
      end
      if (s1_adv) begin
        state <= state_next;
      end
      if (res_free) begin
        res_valid <= s1_valid && s1_last;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
    if (res_free && s1_valid && s1_last) begin
      res_class <= cls;
    end
  end

  assign token_class = res_class;

endmodule
